>>> sv/wli_pkg.sv
// Shared types and constants for the waypoint linear interpolator.
// No dependencies; compiled before every other file of the block.
package wli_pkg;

    localparam int ANGLE_W    = 32;  // Q16.16 joint angle
    localparam int IDX_W      = 3;   // waypoint index registers
    localparam int CNT_W      = 16;  // node counter and num_nodes
    localparam int NWP_W      = 4;   // num_waypoints register
    localparam int DIFF_W     = ANGLE_W + 1;      // end - start
    localparam int PROD_W     = DIFF_W + CNT_W + 1; // signed product
    localparam int DVD_W      = 48;  // magnitude of product always < 2**48
    localparam int QUO_W      = DVD_W + 1;        // signed quotient
    localparam int SUM_W      = QUO_W + 1;        // start + quotient
    localparam int DIV_STEP_W = 6;   // counts DVD_W divider steps

    // Opcodes of the command item
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] REG_NUM_NODES     = 2'd0;
    localparam logic [1:0] REG_NUM_WAYPOINTS = 2'd1;

    localparam logic [CNT_W-1:0] NUM_NODES_RST     = 16'd400;
    localparam logic [NWP_W-1:0] NUM_WAYPOINTS_RST = 4'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_S,
        ST_RD_E,
        ST_DIFF,
        ST_MUL,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_FIX,
        ST_SUM
    } state_t;

    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

>>> sv/wli_if.sv
// Valid/ready channel interfaces: command in, target out, configuration write.
// Depends on nothing; follows wli_pkg in compile order.
interface wli_cmd_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [2:0]         waypoint_slot;
    logic [1:0]         joint_slot;
    logic signed [31:0] angle_in;

    modport source (output valid, opcode, waypoint_slot, joint_slot, angle_in,
                    input ready);
    modport sink   (input valid, opcode, waypoint_slot, joint_slot, angle_in,
                    output ready);
endinterface

interface wli_tgt_if;
    logic               valid;
    logic               ready;
    logic [1:0]         joint_out;
    logic signed [31:0] target_angle;
    logic               last_joint;

    modport source (output valid, joint_out, target_angle, last_joint,
                    input ready);
    modport sink   (input valid, joint_out, target_angle, last_joint,
                    output ready);
endinterface

interface wli_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/wli_div.sv
// Bit-serial restoring divider: unsigned 48-bit dividend by 16-bit divisor.
// Uses wli_pkg; one quotient bit per cycle.
module wli_div
    import wli_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  div_ctl_t           ctl,
    input  logic [DVD_W-1:0]   dividend,
    input  logic [CNT_W-1:0]   divisor,
    output div_sts_t           sts,
    output logic [DVD_W-1:0]   quotient
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_STEP_W-1:0] step_reg;
    logic [CNT_W-1:0]      rem_reg;
    logic [CNT_W-1:0]      rem_next;
    logic [DVD_W-1:0]      quo_reg;
    logic [CNT_W-1:0]      dvs_reg;
    logic [CNT_W:0]        shifted;
    logic [CNT_W+1:0]      trial;
    logic                  qbit;

    // remainder stays below the divisor, so the shifted value fits CNT_W+1 bits
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[DVD_W-1]};
        trial    = {1'b0, shifted} - {2'b00, dvs_reg};
        qbit     = ~trial[CNT_W+1];
        rem_next = qbit ? trial[CNT_W-1:0] : shifted[CNT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            // one-cycle pulse on the last shift
            done_reg <= busy_reg && !ctl.start && (step_reg == DIV_STEP_W'(DVD_W - 1));
            if (ctl.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == DIV_STEP_W'(DVD_W - 1))
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DVD_W-2:0], qbit};
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quotient = quo_reg;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.start |-> !busy_reg)
        else $error("divider started while busy");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held for more than one cycle");
    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> done_reg)
        else $error("divider finished without done");
`endif

endmodule

>>> sv/waypoint_linear_interpolator.sv
// Top level: waypoint table, sequencer, multiplier and output register.
// Uses wli_pkg, the channel interfaces in wli_if.sv and the divider wli_div.
//
//  channel | dir | payload                                       | handshake
//  cmd     | in  | opcode, waypoint_slot, joint_slot, angle_in   | valid/ready
//  target  | out | joint_out, target_angle, last_joint           | valid/ready
//  cfg     | in  | index (0 num_nodes, 1 num_waypoints), data    | valid/ready
//
// A load item writes one table entry when accepted. A tick works through the joints in
// turn: two reads, difference, product, the 48-step bit-serial divider, sign fix and sum.
// cmd.ready is low from tick acceptance until the last target is registered.
// A stalled target output adds its stall to the tick; cfg is always ready.
// Reset clears the counters and the start index, sets the end index to 1, restores the
// configuration defaults (400 nodes, 3 waypoints); table contents are unknown.
module waypoint_linear_interpolator
    import wli_pkg::*;
#(
    parameter int JOINTS        = 4,
    parameter int MAX_WAYPOINTS = 8
)
(
    input  logic   clk,
    input  logic   rst_n,
    wli_cmd_if.sink   cmd,
    wli_tgt_if.source target,
    wli_cfg_if.sink   cfg
);

    localparam int DEPTH  = MAX_WAYPOINTS * JOINTS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int JNT_W  = (JOINTS > 1) ? $clog2(JOINTS) : 1;

    // configuration
    logic [CNT_W-1:0] num_nodes_reg;
    logic [NWP_W-1:0] num_waypoints_reg;
    logic [CNT_W-1:0] div_eff;

    // trajectory state
    logic [CNT_W-1:0] node_cnt_reg;
    logic [IDX_W-1:0] start_idx_reg;
    logic [IDX_W-1:0] end_idx_reg;

    // sequencer
    state_t            state_reg;
    state_t            state_next;
    logic [JNT_W-1:0]  jnt_reg;
    logic              last_jnt;

    // waypoint table
    logic [ANGLE_W-1:0] mem [DEPTH];
    logic [ANGLE_W-1:0] rd_data_reg;
    logic [31:0]        wr_full;
    logic [31:0]        rd_full;
    logic [31:0]        jnt_wide;
    logic [ADDR_W-1:0]  rd_addr;
    logic               load_ok;
    logic               start_ok;
    logic               end_ok;

    // datapath
    logic signed [ANGLE_W-1:0] s_reg;
    logic signed [ANGLE_W-1:0] e_val;
    logic signed [DIFF_W-1:0]  diff_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  prod_mag;
    logic signed [QUO_W-1:0]   q_reg;
    logic signed [SUM_W-1:0]   sum;
    logic signed [ANGLE_W-1:0] sat;
    logic [DVD_W-1:0]          quotient;
    div_ctl_t                  div_ctl;
    div_sts_t                  div_sts;

    // output register
    logic                      out_valid_reg;
    logic [1:0]                out_joint_reg;
    logic signed [ANGLE_W-1:0] out_angle_reg;
    logic                      out_last_reg;
    logic                      out_free;
    logic                      emit;
    logic                      cmd_acc;

    function automatic logic [IDX_W-1:0] step_index(input logic [IDX_W-1:0] idx,
                                                    input logic [NWP_W-1:0] nwp);
        logic [NWP_W-1:0] nxt;
        nxt = {1'b0, idx} + 1'b1;
        if (nxt >= nwp)
            return '0;
        return nxt[IDX_W-1:0];
    endfunction

    // ---------------- configuration ----------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_nodes_reg     <= NUM_NODES_RST;
            num_waypoints_reg <= NUM_WAYPOINTS_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_NUM_NODES:     num_nodes_reg     <= cfg.data;
                REG_NUM_WAYPOINTS: num_waypoints_reg <= cfg.data[NWP_W-1:0];
                default: ;
            endcase
        end
    end

    // a zero step count behaves as one
    assign div_eff = (num_nodes_reg == '0) ? CNT_W'(1) : num_nodes_reg;

    // ---------------- waypoint table ----------------
    assign cmd_acc  = cmd.valid && cmd.ready;
    assign load_ok  = ({29'd0, cmd.waypoint_slot} < 32'(MAX_WAYPOINTS))
                   && ({30'd0, cmd.joint_slot} < 32'(JOINTS));
    assign wr_full  = {29'd0, cmd.waypoint_slot} * 32'(JOINTS) + {30'd0, cmd.joint_slot};
    assign jnt_wide = 32'(jnt_reg);
    // rows past the table read as zero
    assign start_ok = {29'd0, start_idx_reg} < 32'(MAX_WAYPOINTS);
    assign end_ok   = {29'd0, end_idx_reg} < 32'(MAX_WAYPOINTS);
    assign rd_full  = ((state_reg == ST_RD_S) ? {29'd0, start_idx_reg}
                                               : {29'd0, end_idx_reg})
                      * 32'(JOINTS) + jnt_wide;
    assign rd_addr  = rd_full[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd_acc && cmd.opcode == OP_LOAD && load_ok)
            mem[wr_full[ADDR_W-1:0]] <= cmd.angle_in;
        rd_data_reg <= mem[rd_addr];
    end

    // ---------------- sequencer ----------------
    assign cmd.ready = (state_reg == ST_IDLE);
    assign out_free  = !out_valid_reg || target.ready;
    assign last_jnt  = (jnt_wide == 32'(JOINTS - 1));

    always_comb
    begin
        state_next    = state_reg;
        div_ctl.start = 1'b0;
        emit          = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_acc && cmd.opcode == OP_TICK)
                    state_next = ST_RD_S;
            end
            ST_RD_S:     state_next = ST_RD_E;
            ST_RD_E:     state_next = ST_DIFF;
            ST_DIFF:     state_next = ST_MUL;
            ST_MUL:      state_next = ST_DIV_GO;
            ST_DIV_GO:
            begin
                div_ctl.start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_sts.done)
                    state_next = ST_FIX;
            end
            ST_FIX:      state_next = ST_SUM;
            ST_SUM:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = last_jnt ? ST_IDLE : ST_RD_S;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // joint counter and trajectory position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            jnt_reg       <= '0;
            node_cnt_reg  <= '0;
            start_idx_reg <= '0;
            end_idx_reg   <= IDX_W'(1);
        end
        else if (state_reg == ST_IDLE)
            jnt_reg <= '0;
        else if (emit)
        begin
            if (last_jnt)
            begin
                // advance once per tick, after the last joint
                if (({1'b0, node_cnt_reg} + 1'b1) >= {1'b0, div_eff})
                begin
                    node_cnt_reg  <= '0;
                    start_idx_reg <= step_index(start_idx_reg, num_waypoints_reg);
                    end_idx_reg   <= step_index(end_idx_reg, num_waypoints_reg);
                end
                else
                    node_cnt_reg <= node_cnt_reg + 1'b1;
            end
            else
                jnt_reg <= jnt_reg + 1'b1;
        end
    end

    // ---------------- datapath ----------------
    assign e_val    = end_ok ? signed'(rd_data_reg) : '0;
    assign prod_mag = prod_reg[PROD_W-1] ? -prod_reg : prod_reg;

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_RD_E: s_reg    <= start_ok ? signed'(rd_data_reg) : '0;
            ST_DIFF: diff_reg <= DIFF_W'(e_val) - DIFF_W'(s_reg);
            ST_MUL:  prod_reg <= diff_reg * signed'({1'b0, node_cnt_reg});
            // truncation toward zero: divide magnitudes, then restore the sign
            ST_FIX:  q_reg    <= prod_reg[PROD_W-1] ? -signed'({1'b0, quotient})
                                                    :  signed'({1'b0, quotient});
            default: ;
        endcase
    end

    wli_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (prod_mag[DVD_W-1:0]),
        .divisor  (div_eff),
        .sts      (div_sts),
        .quotient (quotient)
    );

    // saturate to the signed 32-bit range (counter above num_nodes)
    always_comb
    begin
        sum = SUM_W'(s_reg) + SUM_W'(q_reg);
        if (sum[SUM_W-1:ANGLE_W-1] == '0 || sum[SUM_W-1:ANGLE_W-1] == '1)
            sat = sum[ANGLE_W-1:0];
        else if (sum[SUM_W-1])
            sat = {1'b1, {(ANGLE_W-1){1'b0}}};
        else
            sat = {1'b0, {(ANGLE_W-1){1'b1}}};
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit)
            out_valid_reg <= 1'b1;
        else if (target.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_joint_reg <= jnt_wide[1:0];
            out_angle_reg <= sat;
            out_last_reg  <= last_jnt;
        end
    end

    assign target.valid        = out_valid_reg;
    assign target.joint_out    = out_joint_reg;
    assign target.target_angle = out_angle_reg;
    assign target.last_joint   = out_last_reg;

`ifndef SYNTHESIS
    a_tick_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready && cmd.opcode == OP_TICK) |=> state_reg == ST_RD_S)
        else $error("tick accepted but sequencer did not start");
    a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_sts.done |-> state_reg == ST_DIV_WAIT)
        else $error("divider result arrived outside its wait state");
    a_cnt_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(node_cnt_reg) |-> $past(state_reg) == ST_SUM)
        else $error("node counter moved outside the final emit");
    a_last_joint: assert property (@(posedge clk) disable iff (!rst_n)
        (target.valid && target.last_joint) |-> target.joint_out == 2'(JOINTS - 1))
        else $error("last flag on the wrong joint");
`endif

endmodule

>>> test/testbench.sv
// Self-checking bench for waypoint_linear_interpolator: a directed table, then random phases
// with random gaps, stalls and one long output hold-off. Needs wli_pkg, the channel
// interfaces of wli_if.sv and the block's RTL; nothing else.
module testbench
    import wli_pkg::*;
;

    localparam int JOINTS        = 4;
    localparam int MAX_WAYPOINTS = 8;
    localparam int RANDOM_ITEMS  = 120;
    localparam int MAX_GAP       = 6;     // per-item idle on either side
    localparam int HOLD_CYCLES   = 600;   // long output hold-off, fills the block
    localparam int SETTLE_CYCLES = 8;     // margin after the last load, before cfg writes
    localparam int DRAIN_CYCLES  = 300;   // over one full tick, catches stray targets
    localparam int DIR_ROWS      = 24;

    localparam longint ANGLE_MAX = 64'sd2147483647;
    localparam longint ANGLE_MIN = -64'sd2147483648;

    typedef enum logic {ROW_CMD, ROW_CFG} row_kind_e;

    // One row of the directed table. For cfg rows value[15:0] is the write data.
    // want is only used where typed is set; it is indexed by joint.
    typedef struct packed {
        row_kind_e                kind;
        logic                     op;
        logic [2:0]               slot;
        logic [1:0]               joint;
        logic [31:0]              value;
        logic [1:0]               reg_idx;
        logic                     typed;
        logic [0:JOINTS-1][31:0]  want;
    } dir_row_t;

    typedef struct packed {
        logic [1:0]         joint;
        logic signed [31:0] angle;
        logic               last;
    } target_t;

    // Directed walk. Reset state is num_nodes 400, num_waypoints 3, rows 0 -> 1.
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // row 0 and row 1: full-scale angles either way, plus +/-1.0
        '{ROW_CMD, OP_LOAD, 3'd0, 2'd0, 32'h7FFF_FFFF, REG_NUM_NODES, 1'b0, '0},
        '{ROW_CMD, OP_LOAD, 3'd0, 2'd1, 32'h8000_0000, REG_NUM_NODES, 1'b0, '0},
        '{ROW_CMD, OP_LOAD, 3'd0, 2'd2, 32'h0000_0000, REG_NUM_NODES, 1'b0, '0},
        '{ROW_CMD, OP_LOAD, 3'd0, 2'd3, 32'h0001_0000, REG_NUM_NODES, 1'b0, '0},
        '{ROW_CMD, OP_LOAD, 3'd1, 2'd0, 32'h8000_0000, REG_NUM_NODES, 1'b0, '0},
        '{ROW_CMD, OP_LOAD, 3'd1, 2'd1, 32'h7FFF_FFFF, REG_NUM_NODES, 1'b0, '0},
        '{ROW_CMD, OP_LOAD, 3'd1, 2'd2, 32'hFFFF_0000, REG_NUM_NODES, 1'b0, '0},
        '{ROW_CMD, OP_LOAD, 3'd1, 2'd3, 32'h0000_0000, REG_NUM_NODES, 1'b0, '0},
        // node 0 gives the start row unchanged
        '{ROW_CMD, OP_TICK, 3'd0, 2'd0, 32'h0, REG_NUM_NODES, 1'b1,
          '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0001_0000}},
        // node 1 of 400, truncating divide
        '{ROW_CMD, OP_TICK, 3'd7, 2'd3, 32'hFFFF_FFFF, REG_NUM_NODES, 1'b0, '0},
        // drop num_nodes to 1 with the counter at 2: overshoot, both rails saturate
        '{ROW_CFG, OP_LOAD, 3'd0, 2'd0, 32'd1, REG_NUM_NODES, 1'b0, '0},
        '{ROW_CMD, OP_TICK, 3'd0, 2'd0, 32'h0, REG_NUM_NODES, 1'b1,
          '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFE_0000, 32'hFFFF_0000}},
        // rows now 1 -> 2
        '{ROW_CMD, OP_LOAD, 3'd2, 2'd0, 32'h0000_0000, REG_NUM_NODES, 1'b0, '0},
        '{ROW_CMD, OP_LOAD, 3'd2, 2'd1, 32'h1234_5678, REG_NUM_NODES, 1'b0, '0},
        '{ROW_CMD, OP_LOAD, 3'd2, 2'd2, 32'hFFFF_FFFF, REG_NUM_NODES, 1'b0, '0},
        '{ROW_CMD, OP_LOAD, 3'd2, 2'd3, 32'h7FFF_FFFF, REG_NUM_NODES, 1'b0, '0},
        '{ROW_CMD, OP_TICK, 3'd0, 2'd0, 32'h0, REG_NUM_NODES, 1'b1,
          '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000, 32'h0000_0000}},
        // rows 2 -> 0 (end wraps at 3); zero num_nodes behaves as 1
        '{ROW_CFG, OP_LOAD, 3'd0, 2'd0, 32'd0, REG_NUM_NODES, 1'b0, '0},
        '{ROW_CMD, OP_TICK, 3'd0, 2'd0, 32'h0, REG_NUM_NODES, 1'b1,
          '{32'h0000_0000, 32'h1234_5678, 32'hFFFF_FFFF, 32'h7FFF_FFFF}},
        // largest num_nodes, all eight rows; upper data bits must not leak in
        '{ROW_CFG, OP_LOAD, 3'd0, 2'd0, 32'h0000_FFFF, REG_NUM_NODES, 1'b0, '0},
        '{ROW_CFG, OP_LOAD, 3'd0, 2'd0, 32'h0000_A5A8, REG_NUM_WAYPOINTS, 1'b0, '0},
        '{ROW_CMD, OP_TICK, 3'd0, 2'd0, 32'h0, REG_NUM_NODES, 1'b1,
          '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'h0001_0000}},
        '{ROW_CMD, OP_TICK, 3'd5, 2'd2, 32'h5555_AAAA, REG_NUM_NODES, 1'b0, '0},
        '{ROW_CMD, OP_LOAD, 3'd7, 2'd3, 32'h5A5A_A5A5, REG_NUM_NODES, 1'b0, '0}
    };

    logic clk = 1'b0;
    logic rst_n;

    wli_cmd_if cmd_bus ();
    wli_tgt_if target_bus ();
    wli_cfg_if cfg_bus ();

    waypoint_linear_interpolator #(
        .JOINTS        (JOINTS),
        .MAX_WAYPOINTS (MAX_WAYPOINTS)
    ) u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_bus),
        .target (target_bus),
        .cfg    (cfg_bus)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Interpolator shadow: table, node counter, row pointers, registers.
    // ---------------------------------------------------------------------
    logic signed [31:0]  wp_angle  [MAX_WAYPOINTS][JOINTS];
    bit                  wp_loaded [MAX_WAYPOINTS][JOINTS];   // table is unknown until loaded
    logic [CNT_W-1:0]    node_idx;
    logic [IDX_W-1:0]    from_row;
    logic [IDX_W-1:0]    to_row;
    logic [CNT_W-1:0]    steps_cfg;
    logic [NWP_W-1:0]    rows_cfg;
    logic signed [31:0]  step_targets [JOINTS];   // targets of the latest tick

    target_t pending_targets [$];   // targets owed by the block, oldest first
    int      mismatch_count = 0;

    logic tx_steady    = 1'b0;   // sender offers back to back
    logic rx_steady    = 1'b0;   // receiver always ready
    logic pressure_go  = 1'b0;
    logic hold_off     = 1'b0;

    // Row pointer step: anything at or past num_waypoints wraps to row 0.
    // Covers num_waypoints of 0 and of 9..15 as well.
    function automatic logic [IDX_W-1:0] advance_row(input logic [IDX_W-1:0] row);
        logic [NWP_W:0] nxt;
        nxt = {2'b00, row} + 5'd1;
        if (nxt >= {1'b0, rows_cfg})
            return '0;
        return nxt[IDX_W-1:0];
    endfunction

    // Apply one accepted command item; returns the number of targets it owes
    // and leaves them in step_targets.
    function automatic int interp_step(input logic op, input logic [2:0] slot,
                                       input logic [1:0] jnt, input logic [31:0] angle);
        longint divisor;
        longint cnt;
        longint s;
        longint e;
        longint q;
        longint t;
        int     j;
        if (op == OP_LOAD)
        begin
            wp_angle[slot][jnt]  = angle;
            wp_loaded[slot][jnt] = 1'b1;
            return 0;
        end
        divisor = steps_cfg;
        if (divisor == 0)
            divisor = 1;   // zero num_nodes acts as one step
        cnt = node_idx;
        for (j = 0; j < JOINTS; j++)
        begin
            s = wp_angle[from_row][j];
            e = wp_angle[to_row][j];
            q = ((e - s) * cnt) / divisor;   // truncates toward zero
            t = s + q;
            // only an overshooting counter (num_nodes lowered) gets out of range
            if (t > ANGLE_MAX)
                t = ANGLE_MAX;
            if (t < ANGLE_MIN)
                t = ANGLE_MIN;
            step_targets[j] = t[31:0];
        end
        if (cnt + 1 >= divisor)
        begin
            node_idx = '0;
            from_row = advance_row(from_row);
            to_row   = advance_row(to_row);
        end
        else
            node_idx = node_idx + 16'd1;
        return JOINTS;
    endfunction

    function automatic logic [31:0] pick_angle();
        logic [31:0] v;
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:
            begin
                v = $urandom_range(0, 262143);   // within +/-4.0
                if ($urandom_range(0, 1) == 1)
                    v = -v;
                return v;
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CNT_W-1:0] pick_nodes();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 16'd1;
            2:       return 16'hFFFF;
            3:       return 16'($urandom_range(7, 65534));
            default: return 16'($urandom_range(2, 6));   // short legs, lots of row stepping
        endcase
    endfunction

    function automatic logic [NWP_W-1:0] pick_rows();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 4'($urandom_range(9, 15));
            2:       return 4'd8;
            default: return 4'($urandom_range(1, 7));
        endcase
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        $display("ERROR at %0t: %s", $time, msg);
    endtask

    // Offer one command item after a random gap, wait for it to be taken,
    // then book the targets it owes (typed ones where the row gives them).
    task automatic send_cmd(input logic op, input logic [2:0] slot, input logic [1:0] jnt,
                            input logic [31:0] angle, input logic typed,
                            input logic [0:JOINTS-1][31:0] want);
        int      gap;
        int      n;
        int      j;
        target_t item;
        gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_bus.valid         <= 1'b1;
        cmd_bus.opcode        <= op;
        cmd_bus.waypoint_slot <= slot;
        cmd_bus.joint_slot    <= jnt;
        cmd_bus.angle_in      <= angle;
        @(posedge clk);
        while (!(cmd_bus.valid && cmd_bus.ready))
            @(posedge clk);
        n = interp_step(op, slot, jnt, angle);
        for (j = 0; j < n; j++)
        begin
            item.joint = 2'(j);
            item.angle = typed ? want[j] : step_targets[j];
            item.last  = (j == JOINTS - 1);
            pending_targets.push_back(item);
        end
    endtask

    // Before a tick, load any entry of the two rows in use that is still unknown.
    task automatic fill_rows();
        int              r;
        int              j;
        logic [IDX_W-1:0] row;
        for (r = 0; r < 2; r++)
        begin
            row = (r == 0) ? from_row : to_row;
            for (j = 0; j < JOINTS; j++)
                if (!wp_loaded[row][j])
                    send_cmd(OP_LOAD, row, 2'(j), pick_angle(), 1'b0, '0);
        end
    endtask

    task automatic random_item();
        if ($urandom_range(0, 9) < 7)
        begin
            fill_rows();
            // payload of a tick is don't-care; randomise it anyway
            send_cmd(OP_TICK, 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                     $urandom, 1'b0, '0);
        end
        else
            send_cmd(OP_LOAD, 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
                     pick_angle(), 1'b0, '0);
    endtask

    // Block idle: input withdrawn, all targets home, last load settled.
    task automatic wait_idle();
        cmd_bus.valid <= 1'b0;
        while (pending_targets.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        cfg_bus.valid <= 1'b1;
        @(posedge clk);
        while (!(cfg_bus.valid && cfg_bus.ready))
            @(posedge clk);
        if (idx == REG_NUM_NODES)
            steps_cfg = data;
        else if (idx == REG_NUM_WAYPOINTS)
            rows_cfg = data[NWP_W-1:0];
        cfg_bus.valid <= 1'b0;
        @(posedge clk);
    endtask

    // ---------------------------------------------------------------------
    // Stimulus: reset, directed table, then random phases.
    // ---------------------------------------------------------------------
    initial
    begin
        dir_row_t row;
        int       rand_sent;
        int       phase;
        int       burst;
        int       i;
        int       j;

        for (i = 0; i < MAX_WAYPOINTS; i++)
            for (j = 0; j < JOINTS; j++)
            begin
                wp_angle[i][j]  = '0;
                wp_loaded[i][j] = 1'b0;
            end
        node_idx  = '0;
        from_row  = 3'd0;
        to_row    = 3'd1;
        steps_cfg = NUM_NODES_RST;
        rows_cfg  = NUM_WAYPOINTS_RST;

        rst_n                 <= 1'b0;
        cmd_bus.valid         <= 1'b0;
        cmd_bus.opcode        <= OP_LOAD;
        cmd_bus.waypoint_slot <= '0;
        cmd_bus.joint_slot    <= '0;
        cmd_bus.angle_in      <= '0;
        cfg_bus.valid         <= 1'b0;
        cfg_bus.index         <= REG_NUM_NODES;
        cfg_bus.data          <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < DIR_ROWS; i++)
        begin
            row = DIRECTED[i];
            if (row.kind == ROW_CFG)
            begin
                wait_idle();
                write_reg(row.reg_idx, row.value[15:0]);
            end
            else
                send_cmd(row.op, row.slot, row.joint, row.value, row.typed, row.want);
        end

        // Each phase: fresh register setting while idle, then a burst of
        // ticks and loads. Lowering num_nodes mid-leg gives counter overshoot.
        rand_sent = 0;
        phase     = 0;
        while (rand_sent < RANDOM_ITEMS)
        begin
            wait_idle();
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_NUM_NODES, pick_nodes());
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_NUM_WAYPOINTS, {12'($urandom), pick_rows()});
            tx_steady = ($urandom_range(0, 3) == 0);
            if (phase == 2)
                pressure_go = 1'b1;   // output held off while this phase keeps offering
            burst = $urandom_range(8, 20);
            repeat (burst)
            begin
                random_item();
                rand_sent++;
            end
            phase++;
        end

        cmd_bus.valid <= 1'b0;
        while (pending_targets.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Receiver: random stall per item, steady stretches, and the hold-off.
    initial
    begin
        int stall;
        target_bus.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 31) == 0)
                rx_steady = !rx_steady;
            stall = rx_steady ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0)
            begin
                target_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            while (hold_off)
            begin
                target_bus.ready <= 1'b0;
                @(posedge clk);
            end
            target_bus.ready <= 1'b1;
            @(posedge clk);
            while (!(target_bus.valid && target_bus.ready))
                @(posedge clk);
        end
    end

    // Long hold-off, counted here so the sender carries on meanwhile.
    initial
    begin
        wait (pressure_go);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Target checker: every accepted item against the oldest booked target.
    always @(posedge clk)
    begin : check_targets
        target_t exp_t;
        if (rst_n && target_bus.valid && target_bus.ready)
        begin
            if (pending_targets.size() == 0)
                flag_mismatch($sformatf("target with none owed: joint %0d angle %h",
                                        target_bus.joint_out, target_bus.target_angle));
            else
            begin
                exp_t = pending_targets.pop_front();
                if (target_bus.joint_out !== exp_t.joint)
                    flag_mismatch($sformatf("joint_out %0d, want %0d",
                                            target_bus.joint_out, exp_t.joint));
                if (target_bus.target_angle !== exp_t.angle)
                    flag_mismatch($sformatf("joint %0d target_angle %h, want %h",
                                            exp_t.joint, target_bus.target_angle,
                                            exp_t.angle));
                if (target_bus.last_joint !== exp_t.last)
                    flag_mismatch($sformatf("joint %0d last_joint %b, want %b",
                                            exp_t.joint, target_bus.last_joint,
                                            exp_t.last));
            end
        end
    end

    // Watchdog, well past the slowest legal run.
    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

>>> sim.f
sv/wli_pkg.sv
sv/wli_if.sv
sv/wli_div.sv
sv/waypoint_linear_interpolator.sv
test/testbench.sv
